// ----- sv/pcpg_pkg.sv -----
package pcpg_pkg;

  localparam int unsigned CordicStagesDef = 18;
  localparam int unsigned PhaseBitsDef    = 24;
  localparam int unsigned CordicW         = 34;
  localparam int unsigned ZW              = 34;
  localparam int unsigned PosW            = 18;
  localparam int unsigned RadW            = 17;
  localparam int unsigned IdxW            = 24;
  localparam int unsigned StepW           = 24;
  localparam int unsigned TotW            = 25;
  localparam int unsigned ShapeW          = 3;
  localparam int unsigned CfgIdxW         = 3;

  localparam logic signed [CordicW-1:0] GainInit = 34'sd652032874;
  localparam logic signed [31:0]        Cos30Q30 = 32'sd929887697;

  typedef enum logic [ShapeW-1:0] {
    SHAPE_HORIZONTAL = 3'd0,
    SHAPE_VERTICAL   = 3'd1,
    SHAPE_LISSAJOUS  = 3'd2,
    SHAPE_FIGURE8    = 3'd3,
    SHAPE_INCLINED   = 3'd4
  } shape_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHAPE  = 3'd0,
    REG_RADIUS = 3'd1,
    REG_FIXX   = 3'd2,
    REG_FIXZ   = 3'd3,
    REG_STEP   = 3'd4,
    REG_TOTAL  = 3'd5
  } reg_idx_e;

  // atan(2^-k) as a 32-bit turn fraction
  function automatic logic signed [ZW-1:0] atan_turn(input int unsigned k);
    logic signed [ZW-1:0] t;
    unique case (k)
      0: t = 34'sd536870912;  1: t = 34'sd316933406;  2: t = 34'sd167458907;
      3: t = 34'sd85004756;   4: t = 34'sd42667331;   5: t = 34'sd21354465;
      6: t = 34'sd10680862;   7: t = 34'sd5340245;    8: t = 34'sd2670163;
      9: t = 34'sd1335087;    10: t = 34'sd667544;    11: t = 34'sd333772;
      12: t = 34'sd166886;    13: t = 34'sd83443;     14: t = 34'sd41722;
      15: t = 34'sd20861;     16: t = 34'sd10430;     17: t = 34'sd5215;
      18: t = 34'sd2608;      19: t = 34'sd1304;      20: t = 34'sd652;
      21: t = 34'sd326;       22: t = 34'sd163;       23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction

  // round half up by 2^sh, then clamp to Q1.16
  function automatic logic signed [PosW-1:0] round_sat(input logic signed [63:0] p,
                                                       input int unsigned sh);
    logic signed [63:0] v;
    v = (p + (64'sd1 <<< (sh - 1))) >>> sh;
    if (v > 64'sd131071) return 18'sd131071;
    if (v < -64'sd131072) return -18'sd131072;
    return v[PosW-1:0];
  endfunction

endpackage

// ----- sv/parametric_curve_point_generator_top.sv -----
// Parametric curve point generator.
// Input: pulse start with sample_index_i while busy is low; busy is
// always low, so a new index may be sent every cycle.
// Config: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; ready is
// always high. Registers: 0 shape, 1 radius, 2 fixed x, 3 fixed z,
// 4 phase step, 5 total points. Write only while no point is in flight.
// Output: done_o strobes for one cycle with x_pos_o, y_pos_o, z_pos_o and
// last_point_o. The receiver cannot stall; beats come out in order.
// Pipeline registers, in order: phase multiply, CORDIC seed, one
// register per CORDIC stage (at most 24), inclined-curve cos30 product,
// radius multiply, rounding/saturation. Throughput: one beat per cycle.
// Three CORDIC pipes run side by side (base angle, angle minus pi/4,
// double angle) so every shape has the same fixed latency.
// Reset clears the valid pipe and the registers to their reset values:
// horizontal, zero radius, phase step 16777, 2000 points.
module parametric_curve_point_generator_top import pcpg_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CordicStagesDef,
  parameter int unsigned PHASE_BITS    = PhaseBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [IdxW-1:0]        sample_index_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  output logic                   done_o,
  output logic signed [PosW-1:0] x_pos_o,
  output logic signed [PosW-1:0] y_pos_o,
  output logic signed [PosW-1:0] z_pos_o,
  output logic                   last_point_o
);

  localparam int unsigned Stg  = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int unsigned Lat  = Stg + 5;

  logic [ShapeW-1:0]      shape_q;
  logic [RadW-1:0]        radius_q;
  logic signed [PosW-1:0] fx_q, fz_q;
  logic [StepW-1:0]       step_q;
  logic [TotW-1:0]        total_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= '0;
      radius_q <= '0;
      fx_q     <= '0;
      fz_q     <= '0;
      step_q   <= StepW'(16777);
      total_q  <= TotW'(2000);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SHAPE:  shape_q  <= cfg_data_i[ShapeW-1:0];
        REG_RADIUS: radius_q <= cfg_data_i[RadW-1:0];
        REG_FIXX:   fx_q     <= cfg_data_i[PosW-1:0];
        REG_FIXZ:   fz_q     <= cfg_data_i[PosW-1:0];
        REG_STEP:   step_q   <= cfg_data_i[StepW-1:0];
        REG_TOTAL:  total_q  <= cfg_data_i[TotW-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // stage 0: phase product and last flag
  logic [PHASE_BITS-1:0] phase_q;
  logic                  last_q [Lat];
  logic                  vld_q  [Lat];

  always_ff @(posedge clk_i) begin
    phase_q <= PHASE_BITS'((PHASE_BITS)'(1) << (PHASE_BITS-1))
             + PHASE_BITS'(sample_index_i * step_q);
    last_q[0] <= (total_q != '0) && ({1'b0, sample_index_i} == total_q - 1'b1);
    for (int i = 1; i < Lat; i++) last_q[i] <= last_q[i-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i < Lat; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  logic signed [CordicW-1:0] c0, s0, c1, s1, c2, s2;

  pcpg_cordic #(.CordicStages(CORDIC_STAGES), .PhaseBits(PHASE_BITS)) u_base (
    .clk_i, .phase_i(phase_q), .cos_o(c0), .sin_o(s0));
  pcpg_cordic #(.CordicStages(CORDIC_STAGES), .PhaseBits(PHASE_BITS)) u_shift (
    .clk_i,
    .phase_i(phase_q - PHASE_BITS'((PHASE_BITS)'(1) << (PHASE_BITS-3))),
    .cos_o(c1), .sin_o(s1));
  pcpg_cordic #(.CordicStages(CORDIC_STAGES), .PhaseBits(PHASE_BITS)) u_dbl (
    .clk_i, .phase_i({phase_q[PHASE_BITS-2:0], 1'b0}),
    .cos_o(c2), .sin_o(s2));

  // stage A: cos * cos30 and register trig
  logic signed [63:0]        tc_q;
  logic signed [CordicW-1:0] c_a, s_a, s1_a, s2_a;
  always_ff @(posedge clk_i) begin
    tc_q <= 64'(c0) * 64'(Cos30Q30);
    c_a  <= c0;
    s_a  <= s0;
    s1_a <= s1;
    s2_a <= s2;
  end

  // stage B: radius products
  logic signed [63:0] pc_q, ps_q, ps1_q, ps2_q, pt_q;
  logic signed [63:0] t_b;
  logic signed [63:0] r64;
  assign r64 = 64'({1'b0, radius_q});
  assign t_b = (tc_q + (64'sd1 <<< 29)) >>> 30;
  always_ff @(posedge clk_i) begin
    pc_q  <= r64 * 64'(c_a);
    ps_q  <= r64 * 64'(s_a);
    ps1_q <= r64 * 64'(s1_a);
    ps2_q <= r64 * 64'(s2_a);
    pt_q  <= r64 * t_b;
  end

  // stage C: round, saturate, select
  always_ff @(posedge clk_i) begin
    unique case (shape_q)
      SHAPE_HORIZONTAL: begin
        x_pos_o <= round_sat(pc_q, 30); y_pos_o <= round_sat(ps_q, 30); z_pos_o <= fz_q;
      end
      SHAPE_VERTICAL: begin
        x_pos_o <= fx_q; y_pos_o <= round_sat(ps_q, 30); z_pos_o <= round_sat(pc_q, 30);
      end
      SHAPE_LISSAJOUS: begin
        x_pos_o <= round_sat(pc_q, 30); y_pos_o <= round_sat(ps1_q, 30); z_pos_o <= fz_q;
      end
      SHAPE_FIGURE8: begin
        x_pos_o <= round_sat(ps2_q, 31); y_pos_o <= round_sat(pc_q, 30); z_pos_o <= fz_q;
      end
      SHAPE_INCLINED: begin
        x_pos_o <= round_sat(pt_q, 30); y_pos_o <= round_sat(ps_q, 30);
        z_pos_o <= round_sat(pc_q, 31);
      end
      default: begin
        x_pos_o <= '0; y_pos_o <= '0; z_pos_o <= '0;
      end
    endcase
  end

  // stage indices: phase 0, cordic 1..Stg+1, A Stg+2, B Stg+3, C Stg+4
  assign done_o       = vld_q[Lat-1];
  assign last_point_o = last_q[Lat-1];

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Lat-2] |=> done_o) else $error("lost beat");
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[Lat-2] |=> !done_o) else $error("invented beat");
  a_start_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> vld_q[0]) else $error("start dropped");

endmodule

// ----- sv/pcpg_cordic.sv -----
module pcpg_cordic import pcpg_pkg::*; #(
  parameter int unsigned CordicStages = CordicStagesDef,
  parameter int unsigned PhaseBits    = PhaseBitsDef
) (
  input  logic                      clk_i,
  input  logic [PhaseBits-1:0]      phase_i,
  output logic signed [CordicW-1:0] cos_o,
  output logic signed [CordicW-1:0] sin_o
);

  localparam int unsigned Stg = (CordicStages < 24) ? CordicStages : 24;

  logic signed [CordicW-1:0] x_q [Stg+1];
  logic signed [CordicW-1:0] y_q [Stg+1];
  logic signed [ZW-1:0]      z_q [Stg+1];
  logic [1:0]                q_q [Stg+1];
  logic [1:0]                q_d;
  logic [PhaseBits-1:0]      d_d;
  logic signed [ZW-1:0]      z_d;

  assign q_d = 2'((phase_i + (PhaseBits)'(1 << (PhaseBits-3))) >> (PhaseBits-2));
  assign d_d = phase_i - {q_d, {(PhaseBits-2){1'b0}}};
  assign z_d = ZW'($signed(d_d)) <<< (32 - PhaseBits);

  always_ff @(posedge clk_i) begin
    x_q[0] <= GainInit;
    y_q[0] <= '0;
    z_q[0] <= z_d;
    q_q[0] <= q_d;
  end

  for (genvar k = 0; k < Stg; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      q_q[k+1] <= q_q[k];
      if (!z_q[k][ZW-1]) begin
        x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] - atan_turn(k);
      end else begin
        x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] + atan_turn(k);
      end
    end
  end

  always_comb begin
    unique case (q_q[Stg])
      2'd0: begin cos_o = x_q[Stg];  sin_o = y_q[Stg];  end
      2'd1: begin cos_o = -y_q[Stg]; sin_o = x_q[Stg];  end
      2'd2: begin cos_o = -x_q[Stg]; sin_o = -y_q[Stg]; end
      default: begin cos_o = y_q[Stg]; sin_o = -x_q[Stg]; end
    endcase
  end

endmodule
